// ===== rtl/core/nss_pkg.sv =====
// ----------------------------------------------------------------------------
// nss_pkg
// register map of the nearest-neighbour scaling address generator
// ----------------------------------------------------------------------------
`default_nettype none

package nss_pkg;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEST_LEFT     = 3'd0,
    REG_DEST_TOP      = 3'd1,
    REG_DEST_WIDTH    = 3'd2,
    REG_DEST_HEIGHT   = 3'd3,
    REG_SOURCE_LEFT   = 3'd4,
    REG_SOURCE_TOP    = 3'd5,
    REG_SOURCE_WIDTH  = 3'd6,
    REG_SOURCE_HEIGHT = 3'd7
  } reg_index_t;

  // flow control between two neighbouring stages
  typedef struct packed {
    logic valid;
    logic before_origin;
  } stage_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/nss_front.sv =====
// ----------------------------------------------------------------------------
// nss_front
// origin subtract, origin check and extent multiply for both axes
// ----------------------------------------------------------------------------
`default_nettype none

module nss_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [COORD_BITS-1:0]   pixel_x,
  input  wire logic [COORD_BITS-1:0]   pixel_y,
  input  wire logic [COORD_BITS-1:0]   dest_left,
  input  wire logic [COORD_BITS-1:0]   dest_top,
  input  wire logic [COORD_BITS-1:0]   source_width,
  input  wire logic [COORD_BITS-1:0]   source_height,
  output nss_pkg::stage_ctrl_t         out_ctrl,
  input  wire logic                    out_ready,
  output logic [2*COORD_BITS-1:0]      dividend_x,
  output logic [2*COORD_BITS-1:0]      dividend_y
);
  import nss_pkg::*;

  logic [COORD_BITS-1:0]   rel_x;
  logic [COORD_BITS-1:0]   rel_y;
  logic                    pre_origin;
  logic [2*COORD_BITS-1:0] product_x;
  logic [2*COORD_BITS-1:0] product_y;

  assign in_ready   = !out_ctrl.valid || out_ready;
  assign pre_origin = (pixel_x < dest_left) || (pixel_y < dest_top);
  // offsets wrap when before the origin, the flag masks that case later
  assign rel_x      = pixel_x - dest_left;
  assign rel_y      = pixel_y - dest_top;
  assign product_x  = (2*COORD_BITS)'(rel_x) * (2*COORD_BITS)'(source_width);
  assign product_y  = (2*COORD_BITS)'(rel_y) * (2*COORD_BITS)'(source_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else if (in_ready) begin
      out_ctrl.valid <= in_valid;
    end
    if (in_ready) begin
      out_ctrl.before_origin <= pre_origin;
      dividend_x             <= product_x;
      dividend_y             <= product_y;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nss_div_cell.sv =====
// ----------------------------------------------------------------------------
// nss_div_cell
// one restoring division step per axis, one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module nss_div_cell #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire nss_pkg::stage_ctrl_t    in_ctrl,
  output logic                         in_ready,
  input  wire logic [COORD_BITS-1:0]   divisor_x,
  input  wire logic [COORD_BITS-1:0]   divisor_y,
  input  wire logic [COORD_BITS-1:0]   in_rem_x,
  input  wire logic [COORD_BITS-1:0]   in_rem_y,
  input  wire logic [2*COORD_BITS-1:0] in_dq_x,
  input  wire logic [2*COORD_BITS-1:0] in_dq_y,
  output nss_pkg::stage_ctrl_t         out_ctrl,
  input  wire logic                    out_ready,
  output logic [COORD_BITS-1:0]        out_rem_x,
  output logic [COORD_BITS-1:0]        out_rem_y,
  output logic [2*COORD_BITS-1:0]      out_dq_x,
  output logic [2*COORD_BITS-1:0]      out_dq_y
);
  import nss_pkg::*;

  logic [COORD_BITS:0]   trial_x;
  logic [COORD_BITS:0]   trial_y;
  logic [COORD_BITS:0]   diff_x;
  logic [COORD_BITS:0]   diff_y;
  logic                  take_x;
  logic                  take_y;
  logic [COORD_BITS-1:0] rem_x_next;
  logic [COORD_BITS-1:0] rem_y_next;

  assign in_ready = !out_ctrl.valid || out_ready;

  // bring down the next dividend bit and try the subtract
  assign trial_x = {in_rem_x, in_dq_x[2*COORD_BITS-1]};
  assign trial_y = {in_rem_y, in_dq_y[2*COORD_BITS-1]};
  assign diff_x  = trial_x - {1'b0, divisor_x};
  assign diff_y  = trial_y - {1'b0, divisor_y};
  assign take_x  = trial_x >= {1'b0, divisor_x};
  assign take_y  = trial_y >= {1'b0, divisor_y};
  assign rem_x_next = take_x ? diff_x[COORD_BITS-1:0] : trial_x[COORD_BITS-1:0];
  assign rem_y_next = take_y ? diff_y[COORD_BITS-1:0] : trial_y[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else if (in_ready) begin
      out_ctrl.valid <= in_ctrl.valid;
    end
    if (in_ready) begin
      out_ctrl.before_origin <= in_ctrl.before_origin;
      out_rem_x              <= rem_x_next;
      out_rem_y              <= rem_y_next;
      out_dq_x               <= {in_dq_x[2*COORD_BITS-2:0], take_x};
      out_dq_y               <= {in_dq_y[2*COORD_BITS-2:0], take_y};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_scale_source_coords.sv =====
// ----------------------------------------------------------------------------
// nearest_scale_source_coords
// nearest-neighbour scaling address generator: destination pixel to
// source column and row
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ------------------------------------
//  in       request    in_valid / in_stall  pixel_x, pixel_y
//  out      result     out_valid/out_stall  source_column, source_row,
//                                           out_of_range
//  cfg      write      cfg_write            cfg_index, cfg_data
//
//  one request per clock sustained while out_stall is low; a request passes
//  the front register, one division cell per quotient bit, the output register
//  reset clears the valid bits of every stage and loads the register defaults
//  a stall on the result side holds only the stages that are full, so empty
//  stages keep filling and the input is stalled once the chain is packed
//
`default_nettype none

module nearest_scale_source_coords #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration
  input  wire logic                               cfg_write,
  input  wire logic [nss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]              cfg_data,
  // pixel requests
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [COORD_BITS-1:0]              pixel_x,
  input  wire logic [COORD_BITS-1:0]              pixel_y,
  // source coordinates
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [COORD_BITS-1:0]                   source_column,
  output logic [COORD_BITS-1:0]                   source_row,
  output logic                                    out_of_range
);
  import nss_pkg::*;

  localparam int STEPS = 2 * COORD_BITS;
  localparam int WIDE  = 2 * COORD_BITS;

  // configuration registers
  logic [COORD_BITS-1:0] dest_left;
  logic [COORD_BITS-1:0] dest_top;
  logic [COORD_BITS-1:0] dest_width;
  logic [COORD_BITS-1:0] dest_height;
  logic [COORD_BITS-1:0] source_left;
  logic [COORD_BITS-1:0] source_top;
  logic [COORD_BITS-1:0] source_width;
  logic [COORD_BITS-1:0] source_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_left     <= '0;
      dest_top      <= '0;
      dest_width    <= COORD_BITS'(1);
      dest_height   <= COORD_BITS'(1);
      source_left   <= '0;
      source_top    <= '0;
      source_width  <= COORD_BITS'(1);
      source_height <= COORD_BITS'(1);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_DEST_LEFT:     dest_left     <= cfg_data;
        REG_DEST_TOP:      dest_top      <= cfg_data;
        REG_DEST_WIDTH:    dest_width    <= cfg_data;
        REG_DEST_HEIGHT:   dest_height   <= cfg_data;
        REG_SOURCE_LEFT:   source_left   <= cfg_data;
        REG_SOURCE_TOP:    source_top    <= cfg_data;
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0 is the front register, stages 1..STEPS are the division cells
  stage_ctrl_t           ctrl   [0:STEPS];
  logic                  ready  [0:STEPS];
  logic [COORD_BITS-1:0] rem_x  [0:STEPS];
  logic [COORD_BITS-1:0] rem_y  [0:STEPS];
  logic [WIDE-1:0]       dq_x   [0:STEPS];
  logic [WIDE-1:0]       dq_y   [0:STEPS];
  logic                  front_ready;
  logic                  out_ready;

  assign in_stall = !front_ready;
  assign rem_x[0] = '0;
  assign rem_y[0] = '0;

  nss_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (front_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .dest_left    (dest_left),
    .dest_top     (dest_top),
    .source_width (source_width),
    .source_height(source_height),
    .out_ctrl     (ctrl[0]),
    .out_ready    (ready[0]),
    .dividend_x   (dq_x[0]),
    .dividend_y   (dq_y[0])
  );

  // the user must keep the divisors stable while requests are in flight (not enforced); each cell reads them
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    nss_div_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctrl  (ctrl[k]),
      .in_ready (ready[k]),
      .divisor_x(dest_width),
      .divisor_y(dest_height),
      .in_rem_x (rem_x[k]),
      .in_rem_y (rem_y[k]),
      .in_dq_x  (dq_x[k]),
      .in_dq_y  (dq_y[k]),
      .out_ctrl (ctrl[k+1]),
      .out_ready(ready[k+1]),
      .out_rem_x(rem_x[k+1]),
      .out_rem_y(rem_y[k+1]),
      .out_dq_x (dq_x[k+1]),
      .out_dq_y (dq_y[k+1])
    );
  end

  // last cell holds the full quotients: add source origin and saturate
  logic [WIDE:0]         sum_x;
  logic [WIDE:0]         sum_y;
  logic                  sat_x;
  logic                  sat_y;
  logic                  pre_origin;
  logic [COORD_BITS-1:0] column_next;
  logic [COORD_BITS-1:0] row_next;
  logic                  flag_next;

  assign out_ready    = !out_valid || !out_stall;
  assign ready[STEPS] = out_ready;
  assign pre_origin   = ctrl[STEPS].before_origin;

  assign sum_x = {1'b0, dq_x[STEPS]} + (WIDE+1)'(source_left);
  assign sum_y = {1'b0, dq_y[STEPS]} + (WIDE+1)'(source_top);
  // zero divisor or anything above the field range pins to the maximum
  assign sat_x = (dest_width == '0)  || (|sum_x[WIDE:COORD_BITS]);
  assign sat_y = (dest_height == '0) || (|sum_y[WIDE:COORD_BITS]);

  always_comb begin
    if (pre_origin) begin
      column_next = '0;
      row_next    = '0;
      flag_next   = 1'b1;
    end else begin
      column_next = sat_x ? '1 : sum_x[COORD_BITS-1:0];
      row_next    = sat_y ? '1 : sum_y[COORD_BITS-1:0];
      flag_next   = sat_x || sat_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= ctrl[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      source_column <= column_next;
      source_row    <= row_next;
      out_of_range  <= flag_next;
    end
  end

endmodule

`default_nettype wire
